### rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("envelope check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("envelope check failed");

`endif

### rtl/adbssr_pkg.sv
`default_nettype none

package adbssr_pkg;

  // default build values
  localparam int SAMPLE_RATE     = 48000;
  localparam int MAX_TICK_FRAMES = 1024;
  localparam int LEVEL_FRAC_BITS = 16;

  // fixed field widths
  localparam int REQ_W       = 2;
  localparam int TICK_W      = 11;
  localparam int SEG_W       = 3;
  localparam int CODE_W      = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int NUM_CFG     = 6;
  localparam int NUM_CODES   = 100;
  localparam int CODE_MAX    = 99;

  // duration curve: 1 ms start in q8 microseconds, ratio per code step in q30
  localparam longint unsigned T0_Q8     = 64'd256000;
  localparam longint unsigned RATIO_Q30 = 64'd1178430322;

  // shortest segment lengths in microseconds
  localparam int MIN_US_ATTACK  = 1500;
  localparam int MIN_US_DECAY   = 2000;
  localparam int MIN_US_RELEASE = 3000;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 2'd0,
    REQ_START   = 2'd1,
    REQ_RELEASE = 2'd2
  } req_type_t;

  typedef enum logic [SEG_W-1:0] {
    SEG_ATTACK  = 3'd0,
    SEG_DECAY   = 3'd1,
    SEG_SLOPE   = 3'd2,
    SEG_SUSTAIN = 3'd3,
    SEG_RELEASE = 3'd4,
    SEG_OFF     = 3'd5
  } seg_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ATTACK_TIME   = 3'd0,
    CFG_DECAY_TIME    = 3'd1,
    CFG_BREAK_LEVEL   = 3'd2,
    CFG_SLOPE_TIME    = 3'd3,
    CFG_SUSTAIN_LEVEL = 3'd4,
    CFG_RELEASE_TIME  = 3'd5
  } cfg_idx_t;

  localparam logic [CODE_W-1:0] CFG_RESET [NUM_CFG] = '{
    7'd1, 7'd50, 7'd85, 7'd50, 7'd75, 7'd35
  };

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic eval;
    logic mul;
    logic div_start;
    logic ramp_apply;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_ramp;
    logic div_done;
  } dp_sts_t;

  // codes above the top of the scale act as the top
  function automatic logic [CODE_W-1:0] sat_code(input logic [CODE_W-1:0] c);
    return (c > CODE_W'(CODE_MAX)) ? CODE_W'(CODE_MAX) : c;
  endfunction

  // raw segment length in frames for a duration code, before the floor
  function automatic longint unsigned frames_raw(input int p, input int sample_rate);
    longint unsigned t;
    int i;
    t = T0_Q8;
    for (i = 0; i < p; i++)
      t = (t * RATIO_Q30 + (64'd1 << 29)) >> 30;
    return (t * longint'(sample_rate) + 64'd128000000) / 64'd256000000;
  endfunction

  // floor in frames for a given minimum time
  function automatic longint unsigned frames_min(input int min_us, input int sample_rate);
    longint unsigned f;
    f = (longint'(min_us) * longint'(sample_rate) + 64'd500000) / 64'd1000000;
    return (f < 64'd1) ? 64'd1 : f;
  endfunction

  // longest segment any code can give
  function automatic longint unsigned frames_max(input int sample_rate);
    longint unsigned a;
    longint unsigned b;
    a = frames_raw(CODE_MAX, sample_rate);
    b = frames_min(MIN_US_RELEASE, sample_rate);
    return (a > b) ? a : b;
  endfunction

  // level code to fixed point, rounded to nearest
  function automatic longint unsigned level_of_code(input int c, input int frac_bits);
    return (longint'(c) * (64'd1 << frac_bits) + 64'd49) / 64'd99;
  endfunction

endpackage

`default_nettype wire

### rtl/adbssr_ifs.sv
`default_nettype none

// request channel
interface adbssr_req_if;
  logic                              valid;
  logic                              ready;
  logic [adbssr_pkg::REQ_W-1:0]      req_type;
  logic [adbssr_pkg::TICK_W-1:0]     tick_frames;

  modport source (output valid, output req_type, output tick_frames, input ready);
  modport sink   (input valid, input req_type, input tick_frames, output ready);
endinterface

// result channel
interface adbssr_rsp_if #(
  parameter int LEVEL_W = adbssr_pkg::LEVEL_FRAC_BITS + 1
);
  logic                              valid;
  logic                              ready;
  logic [LEVEL_W-1:0]                env_level;
  logic [adbssr_pkg::SEG_W-1:0]      env_segment;

  modport source (output valid, output env_level, output env_segment, input ready);
  modport sink   (input valid, input env_level, input env_segment, output ready);
endinterface

`default_nettype wire

### rtl/adbssr_div.sv
`default_nettype none

// restoring divider, one quotient bit a cycle; needs num < den * 2**Q_W
module adbssr_div #(
  parameter int DEN_W = 19,
  parameter int Q_W   = 17
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [DEN_W+Q_W-1:0]   num,
  input  wire logic [DEN_W-1:0]       den,
  output logic                        done,
  output logic [Q_W-1:0]              quot
);

  localparam int NUM_W = DEN_W + Q_W;
  localparam int CNT_W = $clog2(Q_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(Q_W - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W-1:0]   den_q;
  logic [Q_W-1:0]     sh;
  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     trial_sub;
  logic               fits;

  // trial subtract of the shifted partial remainder
  assign trial     = {rem, sh[Q_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign fits      = (trial >= {1'b0, den_q});
  assign quot      = sh;

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST)
          busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[NUM_W-1:Q_W];
      sh    <= num[Q_W-1:0];
      den_q <= den;
    end else if (busy) begin
      rem <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      sh  <= {sh[Q_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### rtl/adbssr_ctrl.sv
`default_nettype none

// sequencer: one request at a time, result held in an output register
module adbssr_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output adbssr_pkg::ctrl_cmd_t       cmd,
  input  wire adbssr_pkg::dp_sts_t    sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV_START,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // commands decoded from state
  always_comb begin
    cmd            = '0;
    cmd.cap        = (state == S_IDLE) && in_valid;
    cmd.eval       = (state == S_EVAL);
    cmd.mul        = (state == S_MUL);
    cmd.div_start  = (state == S_DIV_START);
    cmd.ramp_apply = (state == S_DIV) && sts.div_done;
    cmd.out_load   = (state == S_DONE) && out_free;
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free)
        out_valid <= 1'b1;
      else if (out_valid && out_ready)
        out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid)
            state <= S_EVAL;
        end
        S_EVAL: begin
          state <= sts.need_ramp ? S_MUL : S_DONE;
        end
        S_MUL: begin
          state <= S_DIV_START;
        end
        S_DIV_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (sts.div_done)
            state <= S_DONE;
        end
        S_DONE: begin
          if (out_free)
            state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/adbssr_dp.sv
`default_nettype none

// envelope state, duration and level lookups, ramp multiply and divide
module adbssr_dp #(
  parameter int SAMPLE_RATE     = adbssr_pkg::SAMPLE_RATE,
  parameter int MAX_TICK_FRAMES = adbssr_pkg::MAX_TICK_FRAMES,
  parameter int LEVEL_FRAC_BITS = adbssr_pkg::LEVEL_FRAC_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire adbssr_pkg::ctrl_cmd_t                cmd,
  output adbssr_pkg::dp_sts_t                       sts,
  input  wire logic [adbssr_pkg::REQ_W-1:0]         req_type,
  input  wire logic [adbssr_pkg::TICK_W-1:0]        tick_frames,
  input  wire logic                                 cfg_we,
  input  wire logic [adbssr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [adbssr_pkg::CODE_W-1:0]        cfg_data,
  output logic [LEVEL_FRAC_BITS:0]                  env_level,
  output logic [adbssr_pkg::SEG_W-1:0]              env_segment
);

  localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
  localparam int TICK_W  = adbssr_pkg::TICK_W;
  localparam int CODE_W  = adbssr_pkg::CODE_W;
  localparam int NCODES  = adbssr_pkg::NUM_CODES;
  localparam int NCFG    = adbssr_pkg::NUM_CFG;
  localparam longint unsigned FMAX = adbssr_pkg::frames_max(SAMPLE_RATE);
  localparam int FRAMES_W  = $clog2(FMAX + 1);
  localparam int TICK_TOP  = (1 << TICK_W) - 1;
  localparam int TICK_CAP  = (MAX_TICK_FRAMES > TICK_TOP) ? TICK_TOP : MAX_TICK_FRAMES;
  localparam int ELAPSED_W = $clog2(FMAX + TICK_CAP + 1);
  localparam int NUM_W     = FRAMES_W + LEVEL_W;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(1) << LEVEL_FRAC_BITS;
  localparam logic [FRAMES_W-1:0] FMIN_ATTACK =
    FRAMES_W'(adbssr_pkg::frames_min(adbssr_pkg::MIN_US_ATTACK, SAMPLE_RATE));
  localparam logic [FRAMES_W-1:0] FMIN_DECAY =
    FRAMES_W'(adbssr_pkg::frames_min(adbssr_pkg::MIN_US_DECAY, SAMPLE_RATE));
  localparam logic [FRAMES_W-1:0] FMIN_RELEASE =
    FRAMES_W'(adbssr_pkg::frames_min(adbssr_pkg::MIN_US_RELEASE, SAMPLE_RATE));

  // constant lookup tables
  logic [FRAMES_W-1:0] frames_rom [NCODES];
  logic [LEVEL_W-1:0]  level_rom  [NCODES];

  for (genvar g = 0; g < NCODES; g++) begin : g_rom
    localparam logic [FRAMES_W-1:0] FR = FRAMES_W'(adbssr_pkg::frames_raw(g, SAMPLE_RATE));
    localparam logic [LEVEL_W-1:0]  LV =
      LEVEL_W'(adbssr_pkg::level_of_code(g, LEVEL_FRAC_BITS));
    assign frames_rom[g] = FR;
    assign level_rom[g]  = LV;
  end

  // configuration and envelope state
  logic [CODE_W-1:0]     cfg_regs [NCFG];
  adbssr_pkg::seg_t      segment;
  logic [LEVEL_W-1:0]    level;
  logic [LEVEL_W-1:0]    start_level;
  logic [ELAPSED_W-1:0]  elapsed;
  logic [FRAMES_W-1:0]   seg_frames;

  // captured request and ramp work registers
  logic [adbssr_pkg::REQ_W-1:0] req_q;
  logic [TICK_W-1:0]     tick_q;
  logic [LEVEL_W-1:0]    diff_q;
  logic                  down_q;
  logic [FRAMES_W-1:0]   d_q;
  logic [NUM_W-1:0]      prod_q;

  // evaluation signals
  logic [LEVEL_W-1:0]    lv_break;
  logic [LEVEL_W-1:0]    lv_sus;
  logic [LEVEL_W-1:0]    tgt;
  logic [TICK_W-1:0]     fr;
  logic [FRAMES_W-1:0]   d;
  logic [ELAPSED_W-1:0]  e_new;
  logic                  seg_end;
  logic                  ramping_seg;
  logic [CODE_W-1:0]     lookup_code;
  logic [FRAMES_W-1:0]   lookup_min;
  logic [FRAMES_W-1:0]   raw_frames;
  logic [FRAMES_W-1:0]   new_frames;
  logic [NUM_W-1:0]      div_num;
  logic [LEVEL_W-1:0]    quot;
  logic                  div_done;

  // live target levels
  assign lv_break = level_rom[adbssr_pkg::sat_code(cfg_regs[adbssr_pkg::CFG_BREAK_LEVEL])];
  assign lv_sus   = level_rom[adbssr_pkg::sat_code(cfg_regs[adbssr_pkg::CFG_SUSTAIN_LEVEL])];

  always_comb begin
    case (segment)
      adbssr_pkg::SEG_ATTACK: tgt = FULL_LEVEL;
      adbssr_pkg::SEG_DECAY:  tgt = lv_break;
      adbssr_pkg::SEG_SLOPE:  tgt = lv_sus;
      default:                tgt = '0;
    endcase
  end

  // tick advance and segment end test
  assign fr      = (tick_q > TICK_W'(TICK_CAP)) ? TICK_W'(TICK_CAP) : tick_q;
  assign d       = (seg_frames == '0) ? FRAMES_W'(1) : seg_frames;
  assign e_new   = elapsed + ELAPSED_W'(fr);
  assign seg_end = (e_new >= ELAPSED_W'(d));

  assign ramping_seg = (segment == adbssr_pkg::SEG_ATTACK) ||
                       (segment == adbssr_pkg::SEG_DECAY)  ||
                       (segment == adbssr_pkg::SEG_SLOPE)  ||
                       (segment == adbssr_pkg::SEG_RELEASE);

  assign sts.need_ramp = (req_q == adbssr_pkg::REQ_TICK) && ramping_seg && !seg_end;
  assign sts.div_done  = div_done;

  // one duration lookup per request: pick the code and its floor
  always_comb begin
    case (req_q)
      adbssr_pkg::REQ_START: begin
        lookup_code = cfg_regs[adbssr_pkg::CFG_ATTACK_TIME];
        lookup_min  = FMIN_ATTACK;
      end
      adbssr_pkg::REQ_RELEASE: begin
        lookup_code = cfg_regs[adbssr_pkg::CFG_RELEASE_TIME];
        lookup_min  = FMIN_RELEASE;
      end
      default: begin
        if (segment == adbssr_pkg::SEG_ATTACK)
          lookup_code = cfg_regs[adbssr_pkg::CFG_DECAY_TIME];
        else
          lookup_code = cfg_regs[adbssr_pkg::CFG_SLOPE_TIME];
        lookup_min = FMIN_DECAY;
      end
    endcase
  end

  assign raw_frames = frames_rom[adbssr_pkg::sat_code(lookup_code)];
  assign new_frames = (raw_frames < lookup_min) ? lookup_min : raw_frames;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCFG; i++)
        cfg_regs[i] <= adbssr_pkg::CFG_RESET[i];
    end else if (cfg_we && (cfg_index < adbssr_pkg::CFG_INDEX_W'(NCFG))) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  // envelope state update
  always_ff @(posedge clk) begin
    if (rst) begin
      segment     <= adbssr_pkg::SEG_OFF;
      level       <= '0;
      start_level <= '0;
      elapsed     <= '0;
      seg_frames  <= '0;
    end else if (cmd.eval) begin
      case (req_q)
        adbssr_pkg::REQ_START: begin
          segment     <= adbssr_pkg::SEG_ATTACK;
          level       <= '0;
          start_level <= '0;
          elapsed     <= '0;
          seg_frames  <= new_frames;
        end
        adbssr_pkg::REQ_RELEASE: begin
          if (segment inside {adbssr_pkg::SEG_ATTACK, adbssr_pkg::SEG_DECAY,
                              adbssr_pkg::SEG_SLOPE, adbssr_pkg::SEG_SUSTAIN}) begin
            segment     <= adbssr_pkg::SEG_RELEASE;
            start_level <= level;
            elapsed     <= '0;
            seg_frames  <= new_frames;
          end
        end
        adbssr_pkg::REQ_TICK: begin
          case (segment) inside
            adbssr_pkg::SEG_SUSTAIN: begin
              level <= lv_sus;
            end
            adbssr_pkg::SEG_ATTACK, adbssr_pkg::SEG_DECAY,
            adbssr_pkg::SEG_SLOPE, adbssr_pkg::SEG_RELEASE: begin
              if (seg_end) begin
                // segment finished: land on target, drop the excess time
                level       <= tgt;
                start_level <= tgt;
                elapsed     <= '0;
                case (segment)
                  adbssr_pkg::SEG_ATTACK: begin
                    segment    <= adbssr_pkg::SEG_DECAY;
                    seg_frames <= new_frames;
                  end
                  adbssr_pkg::SEG_DECAY: begin
                    segment    <= adbssr_pkg::SEG_SLOPE;
                    seg_frames <= new_frames;
                  end
                  adbssr_pkg::SEG_SLOPE: begin
                    segment <= adbssr_pkg::SEG_SUSTAIN;
                  end
                  default: begin
                    // release target is zero, so level lands on silence
                    segment <= adbssr_pkg::SEG_OFF;
                  end
                endcase
              end else begin
                elapsed <= e_new;
              end
            end
            default: begin
              level <= '0;
            end
          endcase
        end
        default: ;
      endcase
    end else if (cmd.ramp_apply) begin
      level <= down_q ? (start_level - quot) : (start_level + quot);
    end
  end

  // request capture, ramp operands and result register
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_q  <= req_type;
      tick_q <= tick_frames;
    end
    if (cmd.eval) begin
      diff_q <= (tgt >= start_level) ? (tgt - start_level) : (start_level - tgt);
      down_q <= (tgt < start_level);
      d_q    <= d;
    end
    if (cmd.mul)
      prod_q <= NUM_W'(diff_q) * NUM_W'(elapsed[FRAMES_W-1:0]);
    if (cmd.out_load) begin
      env_level   <= level;
      env_segment <= segment;
    end
  end

  // rounded ramp fraction: (diff * e + d/2) / d
  assign div_num = prod_q + NUM_W'(d_q >> 1);

  adbssr_div #(
    .DEN_W (FRAMES_W),
    .Q_W   (LEVEL_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (d_q),
    .done  (div_done),
    .quot  (quot)
  );

endmodule

`default_nettype wire

### rtl/adbssr_envelope_generator.sv
// channel  dir  beat payload                      handshake
// req      in   req_type[1:0], tick_frames[10:0]  valid/ready
// rsp      out  env_level[LFB:0], env_segment[2:0] valid/ready
// cfg      in   cfg_index[2:0], cfg_data[6:0]     cfg_we, no stall
//
// start, release, and ticks in sustain, off or at a segment end skip the divider
// ramp ticks also pass through the multiply and the one-bit-a-cycle divider
// that forms the rounded ramp fraction
// one request in flight; a new beat is taken while the last result waits
// reset is synchronous and active high; no clearing pass is needed
// a stalled result holds in the output register and holds back only the next result
`default_nettype none

module adbssr_envelope_generator #(
  parameter int SAMPLE_RATE     = adbssr_pkg::SAMPLE_RATE,
  parameter int MAX_TICK_FRAMES = adbssr_pkg::MAX_TICK_FRAMES,
  parameter int LEVEL_FRAC_BITS = adbssr_pkg::LEVEL_FRAC_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  adbssr_req_if.sink                                req,
  adbssr_rsp_if.source                              rsp,
  input  wire logic                                 cfg_we,
  input  wire logic [adbssr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [adbssr_pkg::CODE_W-1:0]        cfg_data
);

  adbssr_pkg::ctrl_cmd_t cmd;
  adbssr_pkg::dp_sts_t   sts;
  logic                  in_ready;
  logic                  out_valid;
  logic [LEVEL_FRAC_BITS:0]          level_out;
  logic [adbssr_pkg::SEG_W-1:0]      seg_out;

  // channel hookup
  assign req.ready       = in_ready;
  assign rsp.valid       = out_valid;
  assign rsp.env_level   = level_out;
  assign rsp.env_segment = seg_out;

  adbssr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  adbssr_dp #(
    .SAMPLE_RATE     (SAMPLE_RATE),
    .MAX_TICK_FRAMES (MAX_TICK_FRAMES),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req.req_type),
    .tick_frames (req.tick_frames),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .env_level   (level_out),
    .env_segment (seg_out)
  );

endmodule

`default_nettype wire

### rtl/adbssr_chk.sv
`default_nettype none

`include "assert_macros.svh"

// port-level checks on the envelope generator
module adbssr_chk #(
  parameter int LEVEL_W = adbssr_pkg::LEVEL_FRAC_BITS + 1
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [LEVEL_W-1:0]             env_level,
  input wire logic [adbssr_pkg::SEG_W-1:0]   env_segment
);

  localparam logic [LEVEL_W-1:0] FULL = LEVEL_W'(1) << (LEVEL_W - 1);
  localparam logic [adbssr_pkg::SEG_W-1:0] OFF_CODE = adbssr_pkg::SEG_OFF;

  // one request in flight: ready drops right after an accepted beat
  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // a stalled result beat holds
  `ASSERT_NEXT(a_rsp_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(env_level) && $stable(env_segment))

  // level never passes full scale
  `ASSERT_IMPLIES(a_level_range, clk, rst, out_valid, env_level <= FULL)

  // the off segment always reports silence
  `ASSERT_IMPLIES(a_off_silent, clk, rst, out_valid && (env_segment == OFF_CODE), env_level == '0)

endmodule

bind adbssr_envelope_generator adbssr_chk #(
  .LEVEL_W (LEVEL_FRAC_BITS + 1)
) u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .env_level   (rsp.env_level),
  .env_segment (rsp.env_segment)
);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import adbssr_pkg::*;

  localparam int TB_SAMPLE_RATE = 48000;
  localparam int TB_MAX_TICK = 1024;
  localparam int TB_FRAC_BITS = 16;
  localparam int TB_LEVEL_W = TB_FRAC_BITS + 1;
  localparam longint unsigned TB_FULL = 64'd1 << TB_FRAC_BITS;
  localparam longint unsigned TB_RATIO_Q30 = 64'd1178430322;
  localparam int ATTACK_FLOOR_US = 1500;
  localparam int DECAY_FLOOR_US = 2000;
  localparam int RELEASE_FLOOR_US = 3000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [TB_LEVEL_W-1:0] lvl;
    logic [SEG_W-1:0]      seg;
  } env_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CODE_W-1:0] cfg_data = '0;

  adbssr_req_if req_if ();
  adbssr_rsp_if rsp_if ();

  adbssr_envelope_generator dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // envelope model state and register mirror
  logic [CODE_W-1:0] cfg_code [NUM_CFG];
  seg_t env_seg;
  longint unsigned env_lvl;
  longint unsigned ramp_from;
  longint unsigned ramp_pos;
  longint unsigned ramp_len;
  longint unsigned dur_frames_raw [100];

  env_result_t expected_env_q [$];
  env_result_t got_beat;
  int mismatch_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("adbssr_envelope_generator verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s want %0d got %0d", cycle_count, what, want, got);
  endtask

  function automatic int unsigned sat99(input logic [CODE_W-1:0] c);
    return (c > 7'd99) ? 99 : int'(c);
  endfunction

  function automatic longint unsigned code_level(input logic [CODE_W-1:0] c);
    return (longint'(sat99(c)) * TB_FULL + 64'd49) / 64'd99;
  endfunction

  function automatic longint unsigned code_frames(input logic [CODE_W-1:0] c,
                                                  input int min_us);
    longint unsigned f;
    longint unsigned floor_f;
    f = dur_frames_raw[sat99(c)];
    floor_f = (longint'(min_us) * TB_SAMPLE_RATE + 64'd500000) / 64'd1000000;
    if (floor_f < 1) floor_f = 1;
    return (f < floor_f) ? floor_f : f;
  endfunction

  function automatic longint unsigned seg_target(input seg_t s);
    case (s)
      SEG_ATTACK: return TB_FULL;
      SEG_DECAY:  return code_level(cfg_code[CFG_BREAK_LEVEL]);
      SEG_SLOPE:  return code_level(cfg_code[CFG_SUSTAIN_LEVEL]);
      default:    return 0;
    endcase
  endfunction

  // one request applied to the envelope model
  function automatic void advance_envelope(input logic [REQ_W-1:0] kind,
                                           input logic [TICK_W-1:0] frames,
                                           output env_result_t res);
    longint unsigned f;
    longint unsigned d;
    longint unsigned tgt;
    longint unsigned m;
    case (kind)
      REQ_TICK: begin
        if (env_seg == SEG_SUSTAIN) begin
          env_lvl = code_level(cfg_code[CFG_SUSTAIN_LEVEL]);
        end else if (env_seg > SEG_RELEASE) begin
          env_lvl = 0;
        end else begin
          f = (frames > TB_MAX_TICK) ? TB_MAX_TICK : frames;
          d = (ramp_len == 0) ? 1 : ramp_len;
          ramp_pos += f;
          tgt = seg_target(env_seg);
          if (ramp_pos >= d) begin
            // segment end: excess time dropped, next segment entered
            env_lvl = tgt;
            ramp_from = tgt;
            ramp_pos = 0;
            case (env_seg)
              SEG_ATTACK: begin
                env_seg = SEG_DECAY;
                ramp_len = code_frames(cfg_code[CFG_DECAY_TIME], DECAY_FLOOR_US);
              end
              SEG_DECAY: begin
                env_seg = SEG_SLOPE;
                ramp_len = code_frames(cfg_code[CFG_SLOPE_TIME], DECAY_FLOOR_US);
              end
              SEG_SLOPE: env_seg = SEG_SUSTAIN;
              default: begin
                env_seg = SEG_OFF;
                env_lvl = 0;
                ramp_from = 0;
              end
            endcase
          end else if (tgt >= ramp_from) begin
            m = ((tgt - ramp_from) * ramp_pos + d / 2) / d;
            env_lvl = ramp_from + m;
          end else begin
            m = ((ramp_from - tgt) * ramp_pos + d / 2) / d;
            env_lvl = ramp_from - m;
          end
        end
      end
      REQ_START: begin
        env_seg = SEG_ATTACK;
        env_lvl = 0;
        ramp_from = 0;
        ramp_pos = 0;
        ramp_len = code_frames(cfg_code[CFG_ATTACK_TIME], ATTACK_FLOOR_US);
      end
      REQ_RELEASE: begin
        if (env_seg < SEG_RELEASE) begin
          env_seg = SEG_RELEASE;
          ramp_from = env_lvl;
          ramp_pos = 0;
          ramp_len = code_frames(cfg_code[CFG_RELEASE_TIME], RELEASE_FLOOR_US);
        end
      end
      default: ;
    endcase
    res.lvl = env_lvl[TB_LEVEL_W-1:0];
    res.seg = env_seg;
  endfunction

  // request beat: optional gap, then hold valid until accepted
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [TICK_W-1:0] frames);
    env_result_t res;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.req_type = kind;
    req_if.tick_frames = frames;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    advance_envelope(kind, frames, res);
    expected_env_q.push_back(res);
    items_sent++;
  endtask

  // stop sending and wait for every result
  task automatic drain;
    @(negedge clk);
    req_if.valid = 1'b0;
    while (expected_env_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input logic [CODE_W-1:0] atk, input logic [CODE_W-1:0] dcy,
                               input logic [CODE_W-1:0] brk, input logic [CODE_W-1:0] slp,
                               input logic [CODE_W-1:0] sus, input logic [CODE_W-1:0] rel);
    logic [CODE_W-1:0] vals [NUM_CFG];
    vals[CFG_ATTACK_TIME] = atk;
    vals[CFG_DECAY_TIME] = dcy;
    vals[CFG_BREAK_LEVEL] = brk;
    vals[CFG_SLOPE_TIME] = slp;
    vals[CFG_SUSTAIN_LEVEL] = sus;
    vals[CFG_RELEASE_TIME] = rel;
    for (int i = 0; i < NUM_CFG; i++) begin
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_index = CFG_INDEX_W'(i);
      cfg_data = vals[i];
      cfg_code[i] = vals[i];
      @(posedge clk);
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [TICK_W-1:0] pick_frames;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return TICK_W'(TB_MAX_TICK);
      2: return TICK_W'($urandom_range(TB_MAX_TICK + 1, 2047));
      3: return TICK_W'($urandom_range(1, 16));
      default: return TICK_W'($urandom_range(1, 700));
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_time_code;
    case ($urandom_range(0, 19))
      0: return '0;
      1: return CODE_W'($urandom_range(99, 127));
      default: return CODE_W'($urandom_range(0, 45));
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_level_code;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CODE_W'($urandom_range(99, 127));
      default: return CODE_W'($urandom_range(0, 99));
    endcase
  endfunction

  // start, held ticks, then mostly a release and its tail
  task automatic play_note;
    send_req(REQ_START, TICK_W'($urandom_range(0, 2047)));
    repeat ($urandom_range(1, 24)) begin
      if ($urandom_range(0, 29) == 0) send_req(REQ_START, pick_frames());
      else send_req(REQ_TICK, pick_frames());
    end
    if ($urandom_range(0, 9) != 0) begin
      send_req(REQ_RELEASE, TICK_W'($urandom_range(0, 2047)));
      if ($urandom_range(0, 7) == 0) send_req(REQ_RELEASE, pick_frames());
      repeat ($urandom_range(1, 8)) send_req(REQ_TICK, pick_frames());
    end
  endtask

  // requests while off
  task automatic test_idle_requests;
    send_req(REQ_TICK, '0);
    send_req(REQ_RELEASE, 11'd2047);
    send_req(REQ_UNUSED, 11'd2047);
  endtask

  // reset settings, walk through attack, decay, release and off
  task automatic test_note_walk;
    send_req(REQ_START, 11'd2047);
    send_req(REQ_TICK, '0);
    send_req(REQ_TICK, 11'd36);
    send_req(REQ_TICK, 11'd2047);
    send_req(REQ_TICK, 11'd1024);
    send_req(REQ_RELEASE, '0);
    send_req(REQ_RELEASE, 11'd5);
    send_req(REQ_UNUSED, 11'd1);
    send_req(REQ_TICK, 11'd1024);
    send_req(REQ_TICK, 11'd1024);
    send_req(REQ_TICK, 11'd5);
    send_req(REQ_START, '0);
    send_req(REQ_RELEASE, '0);
  endtask

  // sustain follows the live sustain register
  task automatic test_sustain_live;
    drain;
    load_settings(7'd0, 7'd0, 7'd127, 7'd0, 7'd99, 7'd0);
    send_req(REQ_START, '0);
    send_req(REQ_TICK, 11'd2047);
    send_req(REQ_TICK, 11'd2047);
    send_req(REQ_TICK, 11'd2047);
    send_req(REQ_TICK, 11'd7);
    drain;
    load_settings(7'd0, 7'd0, 7'd127, 7'd0, 7'd0, 7'd0);
    send_req(REQ_TICK, '0);
    send_req(REQ_RELEASE, '0);
    send_req(REQ_TICK, 11'd1024);
  endtask

  // longest and shortest settings
  task automatic test_extreme_settings;
    drain;
    load_settings(7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127);
    send_req(REQ_START, '0);
    send_req(REQ_TICK, 11'd2047);
    send_req(REQ_TICK, 11'd1);
    send_req(REQ_RELEASE, '0);
    send_req(REQ_TICK, 11'd1024);
    drain;
    load_settings(7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99);
    send_req(REQ_TICK, 11'd1000);
    send_req(REQ_START, '0);
    send_req(REQ_TICK, 11'd513);
    drain;
    load_settings(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
    play_note;
    drain;
    load_settings(7'd0, 7'd0, 7'd99, 7'd0, 7'd0, 7'd0);
    play_note;
  endtask

  // random settings per phase, mostly whole notes with some noise
  task automatic test_random_notes;
    int goal;
    goal = items_sent + 560;
    while (items_sent < goal) begin
      drain;
      if (items_sent > goal - 130) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      load_settings(pick_time_code(), pick_time_code(), pick_level_code(),
                    pick_time_code(), pick_level_code(), pick_time_code());
      // leftover note continues under the new settings
      repeat ($urandom_range(0, 2)) send_req(REQ_TICK, pick_frames());
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 6))
            send_req(REQ_W'($urandom_range(0, 3)), TICK_W'($urandom_range(0, 2047)));
        end else begin
          play_note;
        end
      end
    end
  endtask

  // result sink with random stall bursts
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_if.ready = 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  // result beat check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_env_q.size() == 0) begin
        report_mismatch("result beat with nothing pending, level", 0, rsp_if.env_level);
      end else begin
        got_beat = expected_env_q.pop_front();
        if (rsp_if.env_level !== got_beat.lvl)
          report_mismatch("env_level", got_beat.lvl, rsp_if.env_level);
        if (rsp_if.env_segment !== got_beat.seg)
          report_mismatch("env_segment", got_beat.seg, rsp_if.env_segment);
      end
    end
  end

  initial begin
    longint unsigned t;
    req_if.valid = 1'b0;
    req_if.req_type = '0;
    req_if.tick_frames = '0;

    // duration curve in frames per code
    t = 64'd256000;
    for (int i = 0; i < 100; i++) begin
      dur_frames_raw[i] = (t * TB_SAMPLE_RATE + 64'd128000000) / 64'd256000000;
      t = (t * TB_RATIO_Q30 + (64'd1 << 29)) >> 30;
    end

    // reset state of the model
    cfg_code[CFG_ATTACK_TIME] = 7'd1;
    cfg_code[CFG_DECAY_TIME] = 7'd50;
    cfg_code[CFG_BREAK_LEVEL] = 7'd85;
    cfg_code[CFG_SLOPE_TIME] = 7'd50;
    cfg_code[CFG_SUSTAIN_LEVEL] = 7'd75;
    cfg_code[CFG_RELEASE_TIME] = 7'd35;
    env_seg = SEG_OFF;
    env_lvl = 0;
    ramp_from = 0;
    ramp_pos = 0;
    ramp_len = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_requests;
    test_note_walk;
    test_sustain_live;
    test_extreme_settings;
    test_random_notes;

    drain;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_env_q.size() == 0)
      $display("adbssr_envelope_generator verification clean");
    else
      $display("adbssr_envelope_generator verification failed");
    $finish;
  end

endmodule
